@@ hw/rtl/mpsq_pkg.sv @@
// Shared constants, types and controller commands for the masked pending signal queue.
// No dependencies; every other file except mpsq_ram refers to this package by scoped names.
package mpsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_SIGNALS = 16;

  localparam int SIG_IN_W = 8;
  localparam int SIG_W    = 4;
  localparam int MASK_W   = 16;
  localparam int IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int PCNT_W   = 5;
  localparam int OUT_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MASK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MASK = CFG_IDX_W'(1);

  localparam logic KIND_POST = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POST,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic post;
    logic scan_rd;
    logic take_hit;
    logic idx_inc;
    logic shift_rd;
    logic shift_wr;
    logic cnt_dec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic scan_end;
    logic hit;
    logic shift_more;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/masked_pending_signal_queue.sv @@
// Top level of the masked pending signal queue: controller plus datapath.
// Depends on mpsq_pkg, mpsq_ctrl, mpsq_dp (and mpsq_ram through the datapath).
//
// A 16-deep FIFO of pending signal ids. A post (in_tuser = 0) appends
// in_tdata when the id is below 16 and the queue is not full, else it
// returns post_dropped. A take (in_tuser = 1) returns and removes the
// oldest entry whose bit is clear in both block masks, closing the gap.
// One item is handled at a time and each gives one result. A post goes
// from accept to result through the post and done states; a take walks
// the slot RAM one entry at a time (read, then check) and, on a hit,
// compacts the newer entries one at a time (read, then write). The
// single-read-port slot RAM sets that pace. Mask writes on the cfg
// channel are always accepted.
module masked_pending_signal_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  // cfg
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mpsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpsq_pkg::MASK_W-1:0]    cfg_data,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mpsq_pkg::SIG_IN_W-1:0]  in_tdata,   // [7:0] signal_number
  input  logic                           in_tuser,   // [0] kind
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] taken_valid, [4:1] taken_signal, [5] post_dropped,
  // [10:6] pending_count, [15:11] zero
  output logic [mpsq_pkg::OUT_W-1:0]     out_tdata
);

  mpsq_pkg::cmd_t    cmd;
  mpsq_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  mpsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpsq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ hw/rtl/mpsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the queue slots.
module mpsq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/mpsq_ctrl.sv @@
// Controller state machine: sequences post, scan and compaction steps.
// Depends on mpsq_pkg for the state enum and the command/status structs.
module mpsq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  mpsq_pkg::status_t sts,
  output mpsq_pkg::cmd_t    cmd
);

  mpsq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpsq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpsq_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (sts.kind == mpsq_pkg::KIND_POST) ? mpsq_pkg::ST_POST
                                                        : mpsq_pkg::ST_SCAN_RD;
        end
      end
      mpsq_pkg::ST_POST:     state_nxt = mpsq_pkg::ST_DONE;
      mpsq_pkg::ST_SCAN_RD:  state_nxt = sts.scan_end ? mpsq_pkg::ST_DONE
                                                      : mpsq_pkg::ST_SCAN_CHK;
      mpsq_pkg::ST_SCAN_CHK: state_nxt = sts.hit ? mpsq_pkg::ST_SHIFT_RD
                                                 : mpsq_pkg::ST_SCAN_RD;
      mpsq_pkg::ST_SHIFT_RD: state_nxt = sts.shift_more ? mpsq_pkg::ST_SHIFT_WR
                                                        : mpsq_pkg::ST_DONE;
      mpsq_pkg::ST_SHIFT_WR: state_nxt = mpsq_pkg::ST_SHIFT_RD;
      mpsq_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = mpsq_pkg::ST_IDLE;
        end
      end
      default:               state_nxt = mpsq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      mpsq_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
      end
      mpsq_pkg::ST_POST:     cmd.post = 1'b1;
      mpsq_pkg::ST_SCAN_RD:  cmd.scan_rd = !sts.scan_end;
      mpsq_pkg::ST_SCAN_CHK: begin
        cmd.take_hit = sts.hit;
        cmd.idx_inc  = !sts.hit;
      end
      mpsq_pkg::ST_SHIFT_RD: begin
        cmd.shift_rd = sts.shift_more;
        cmd.cnt_dec  = !sts.shift_more;
      end
      mpsq_pkg::ST_SHIFT_WR: cmd.shift_wr = 1'b1;
      mpsq_pkg::ST_DONE:     cmd.out_load = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/mpsq_dp.sv @@
// Datapath: masks, item registers, entry count, scan index, slot RAM and output register.
// Depends on mpsq_pkg and mpsq_ram; driven by commands from mpsq_ctrl.
module mpsq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [mpsq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpsq_pkg::MASK_W-1:0]       cfg_data,
  input  logic                              in_tuser,
  input  logic [mpsq_pkg::SIG_IN_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mpsq_pkg::OUT_W-1:0]        out_tdata,
  input  mpsq_pkg::cmd_t                    cmd,
  output mpsq_pkg::status_t                 sts
);

  logic [mpsq_pkg::MASK_W-1:0]   local_mask_r, global_mask_r;
  logic [mpsq_pkg::SIG_IN_W-1:0] sig_r;
  logic [mpsq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [mpsq_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic                          valid_r, dropped_r;
  logic [mpsq_pkg::SIG_W-1:0]    taken_r;
  logic                          out_valid_r;
  logic [mpsq_pkg::OUT_W-1:0]    out_data_r;

  logic                          post_ok;
  logic [mpsq_pkg::CNT_W-1:0]    idx_plus1;
  logic                          ram_we, ram_re;
  logic [mpsq_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [mpsq_pkg::SIG_W-1:0]    ram_wdata, ram_rdata;
  logic [mpsq_pkg::MASK_W-1:0]   block_mask;

  // Configuration is accepted every cycle; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mask_r  <= '0;
      global_mask_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mpsq_pkg::REG_LOCAL_MASK:  local_mask_r  <= cfg_data;
        mpsq_pkg::REG_GLOBAL_MASK: global_mask_r <= cfg_data;
        default: begin
          local_mask_r <= local_mask_r;
        end
      endcase
    end
  end

  assign block_mask = local_mask_r | global_mask_r;
  assign idx_plus1  = idx_r + mpsq_pkg::CNT_W'(1);
  assign post_ok    = (sig_r < mpsq_pkg::SIG_IN_W'(mpsq_pkg::NUM_SIGNALS)) &&
                      (count_r < mpsq_pkg::CNT_W'(mpsq_pkg::QUEUE_DEPTH));

  // Slot RAM: posts write at the tail, compaction writes one slot down.
  always_comb begin
    ram_we    = (cmd.post && post_ok) || cmd.shift_wr;
    ram_waddr = cmd.post ? count_r[mpsq_pkg::IDX_W-1:0] : idx_r[mpsq_pkg::IDX_W-1:0];
    ram_wdata = cmd.post ? sig_r[mpsq_pkg::SIG_W-1:0] : ram_rdata;
    ram_re    = cmd.scan_rd || cmd.shift_rd;
    ram_raddr = cmd.shift_rd ? idx_plus1[mpsq_pkg::IDX_W-1:0]
                             : idx_r[mpsq_pkg::IDX_W-1:0];
  end

  mpsq_ram #(
    .WIDTH (mpsq_pkg::SIG_W),
    .DEPTH (mpsq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.post && post_ok) begin
      count_nxt = count_r + mpsq_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - mpsq_pkg::CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.load_item) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc || cmd.shift_wr) begin
      idx_nxt = idx_plus1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_item) begin
      sig_r     <= in_tdata;
      valid_r   <= 1'b0;
      dropped_r <= 1'b0;
      taken_r   <= '0;
    end
    if (cmd.post) begin
      dropped_r <= !post_ok;
    end
    if (cmd.take_hit) begin
      valid_r <= 1'b1;
      taken_r <= ram_rdata;
    end
  end

  // Output register: hold the result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= mpsq_pkg::OUT_W'({mpsq_pkg::PCNT_W'(count_r), dropped_r, taken_r, valid_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.kind       = in_tuser;
  assign sts.scan_end   = (idx_r >= count_r);
  assign sts.hit        = !block_mask[ram_rdata];
  assign sts.shift_more = (idx_plus1 < count_r);
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule
